// ----- src/rti_pkg.sv -----
// Shared constants, payload types and register codes for the ray/triangle test.
// Used by every file of the block; no dependencies of its own.
package rti_pkg;

   localparam int COORD_W   = 32;
   localparam int EDGE_W    = COORD_W + 1;
   localparam int SCALED_W  = 3 * EDGE_W + 4;
   localparam int TQ_W      = 62;
   localparam int TQ_HALF   = TQ_W / 2;
   localparam int DIST_W    = 31;
   localparam int ROOT_W    = 32;
   localparam int SUMSQ_W   = 64;
   localparam int ISQ_STEPS = ROOT_W;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_AX    = 3;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_ORIGIN_Z,
      REG_DIRECTION_X,
      REG_DIRECTION_Y,
      REG_DIRECTION_Z
   } csr_idx_type;

   typedef struct packed {
      logic miss;
      logic ovf;
   } div_tag_type;

   typedef struct packed {
      logic      miss;
      logic      far;
      coord_type px;
      coord_type py;
      coord_type pz;
   } sq_tag_type;

   typedef struct packed {
      logic              hit;
      coord_type         point_x;
      coord_type         point_y;
      coord_type         point_z;
      logic [DIST_W-1:0] distance;
   } rsp_type;

endpackage

// ----- src/rti_if.sv -----
// Channel interfaces: triangle requests, hit responses and register writes.
// Depends on rti_pkg for coordinate types and widths.
interface rti_req_if;
   logic               valid;
   logic               ready;
   rti_pkg::coord_type vert0_x;
   rti_pkg::coord_type vert0_y;
   rti_pkg::coord_type vert0_z;
   rti_pkg::coord_type vert1_x;
   rti_pkg::coord_type vert1_y;
   rti_pkg::coord_type vert1_z;
   rti_pkg::coord_type vert2_x;
   rti_pkg::coord_type vert2_y;
   rti_pkg::coord_type vert2_z;

   modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                   vert2_x, vert2_y, vert2_z, input ready);
   modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                 vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   rti_pkg::coord_type           point_x;
   rti_pkg::coord_type           point_y;
   rti_pkg::coord_type           point_z;
   logic [rti_pkg::DIST_W-1:0]   distance;

   modport source (output valid, hit, point_x, point_y, point_z, distance, input ready);
   modport sink (input valid, hit, point_x, point_y, point_z, distance, output ready);
endinterface

interface rti_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rti_pkg::CSR_IDX_W-1:0] index;
   logic [rti_pkg::COORD_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/rti_geom.sv -----
// Front end: edge vectors, cross products, split dot products, sign fix and
// the hit tests. Eight register stages. Depends on rti_pkg.
module rti_geom #(
   parameter int FRAC_BITS = 16,
   localparam int WDOT = rti_pkg::SCALED_W - FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rti_pkg::coord_type            vert0 [rti_pkg::NUM_AX],
   input  rti_pkg::coord_type            vert1 [rti_pkg::NUM_AX],
   input  rti_pkg::coord_type            vert2 [rti_pkg::NUM_AX],
   input  rti_pkg::coord_type            org [rti_pkg::NUM_AX],
   input  rti_pkg::coord_type            dir [rti_pkg::NUM_AX],
   output logic                          out_valid,
   output logic [rti_pkg::SCALED_W-1:0]  out_rem,
   output logic [WDOT-1:0]               out_den,
   output rti_pkg::div_tag_type          out_tag
);

   localparam int NA  = rti_pkg::NUM_AX;
   localparam int WE  = rti_pkg::EDGE_W;
   localparam int WX  = 2 * WE + 1;
   localparam int WQ  = WX - FRAC_BITS;
   localparam int SPL = (WQ + 1) / 2;
   localparam int WLO = WE + SPL + 1;
   localparam int WHI = WE + WQ - SPL;
   localparam int WP  = WE + WQ;
   localparam int WS  = rti_pkg::SCALED_W;
   localparam int NPR = 4 * NA;
   localparam int NDOT = 4;
   localparam int NSTG = 8;
   localparam logic signed [WDOT-1:0] LSB_D = WDOT'(1) <<< FRAC_BITS;

   logic [NSTG-1:0] vld_ff;

   // stage 1: edges and origin offset
   logic signed [WE-1:0] e1_in [NA], e2_in [NA], s_in [NA];
   logic signed [WE-1:0] e1_s1_ff [NA], e2_s1_ff [NA], s_s1_ff [NA];
   // stage 2: raw cross product terms
   logic signed [WX-1:0] hpa_in [NA], hpb_in [NA], qpa_in [NA], qpb_in [NA];
   logic signed [WX-1:0] hpa_ff [NA], hpb_ff [NA], qpa_ff [NA], qpb_ff [NA];
   logic signed [WE-1:0] e1_s2_ff [NA], e2_s2_ff [NA], s_s2_ff [NA];
   // stage 3: floored cross products
   logic signed [WQ-1:0] h_in [NA], q_in [NA], h_ff [NA], q_ff [NA];
   logic signed [WE-1:0] e1_s3_ff [NA], e2_s3_ff [NA], s_s3_ff [NA];
   // stage 4: partial products
   logic signed [WE-1:0]  opa [NPR];
   logic signed [WQ-1:0]  opb [NPR];
   logic signed [WLO-1:0] plo_in [NPR], plo_ff [NPR];
   logic signed [WHI-1:0] phi_in [NPR], phi_ff [NPR];
   // stage 5: full products
   logic signed [WP-1:0] prod_in [NPR], prod_ff [NPR];
   // stage 6: det, un, vn, tn
   logic signed [WDOT-1:0] dot_in [NDOT], dot_ff [NDOT];
   // stage 7: sign fixed
   logic signed [WDOT-1:0] an_in [NDOT], an_ff [NDOT];
   logic                   par_in, par_ff;
   // stage 8: tests
   logic signed [WS-1:0]   scaled;
   logic signed [WDOT-1:0] sum_uv;
   logic                   miss_in, ovf_in;
   logic [WS-1:0]          rem_ff;
   logic [WDOT-1:0]        den_ff;
   rti_pkg::div_tag_type   tag_ff;

   genvar k, j, d;

   generate
      for (k = 0; k < NA; k++) begin : g_ax
         localparam int K1 = (k + 1) % NA;
         localparam int K2 = (k + 2) % NA;
         assign e1_in[k]  = WE'(vert1[k]) - WE'(vert0[k]);
         assign e2_in[k]  = WE'(vert2[k]) - WE'(vert0[k]);
         assign s_in[k]   = WE'(org[k]) - WE'(vert0[k]);
         assign hpa_in[k] = WX'(dir[K1] * e2_s1_ff[K2]);
         assign hpb_in[k] = WX'(dir[K2] * e2_s1_ff[K1]);
         assign qpa_in[k] = WX'(s_s1_ff[K1] * e1_s1_ff[K2]);
         assign qpb_in[k] = WX'(s_s1_ff[K2] * e1_s1_ff[K1]);
         assign h_in[k]   = WQ'((hpa_ff[k] - hpb_ff[k]) >>> FRAC_BITS);
         assign q_in[k]   = WQ'((qpa_ff[k] - qpb_ff[k]) >>> FRAC_BITS);
         assign opa[k]          = e1_s3_ff[k];
         assign opb[k]          = h_ff[k];
         assign opa[NA + k]     = s_s3_ff[k];
         assign opb[NA + k]     = h_ff[k];
         assign opa[2 * NA + k] = WE'(dir[k]);
         assign opb[2 * NA + k] = q_ff[k];
         assign opa[3 * NA + k] = e2_s3_ff[k];
         assign opb[3 * NA + k] = q_ff[k];
      end

      for (j = 0; j < NPR; j++) begin : g_prod
         assign plo_in[j]  = WLO'(opa[j] * $signed({1'b0, opb[j][SPL-1:0]}));
         assign phi_in[j]  = WHI'(opa[j] * $signed(opb[j][WQ-1:SPL]));
         assign prod_in[j] = (WP'(phi_ff[j]) <<< SPL) + WP'(plo_ff[j]);
      end

      for (d = 0; d < NDOT; d++) begin : g_dot
         assign dot_in[d] = WDOT'(prod_ff[NA * d]) + WDOT'(prod_ff[NA * d + 1])
                          + WDOT'(prod_ff[NA * d + 2]);
         // flip all four so that det comes out positive
         assign an_in[d]  = dot_ff[0][WDOT-1] ? -dot_ff[d] : dot_ff[d];
      end
   endgenerate

   assign par_in = (dot_ff[0] < LSB_D) && (dot_ff[0] > -LSB_D);

   always_comb begin
      scaled  = WS'(an_ff[3]) <<< FRAC_BITS;
      sum_uv  = an_ff[1] + an_ff[2];
      miss_in = par_ff || an_ff[1][WDOT-1] || (an_ff[1] > an_ff[0]) || an_ff[2][WDOT-1]
             || (sum_uv > an_ff[0]) || (scaled <= WS'(an_ff[0]));
      // quotient would not fit the cap width
      ovf_in  = (scaled >>> rti_pkg::TQ_W) >= WS'(an_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_s1_ff <= e1_in;
         e2_s1_ff <= e2_in;
         s_s1_ff  <= s_in;
         hpa_ff   <= hpa_in;
         hpb_ff   <= hpb_in;
         qpa_ff   <= qpa_in;
         qpb_ff   <= qpb_in;
         e1_s2_ff <= e1_s1_ff;
         e2_s2_ff <= e2_s1_ff;
         s_s2_ff  <= s_s1_ff;
         h_ff     <= h_in;
         q_ff     <= q_in;
         e1_s3_ff <= e1_s2_ff;
         e2_s3_ff <= e2_s2_ff;
         s_s3_ff  <= s_s2_ff;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         prod_ff  <= prod_in;
         dot_ff   <= dot_in;
         an_ff    <= an_in;
         par_ff   <= par_in;
         rem_ff   <= scaled;
         den_ff   <= an_ff[0];
         tag_ff.miss <= miss_in;
         tag_ff.ovf  <= ovf_in;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- src/rti_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Produces floor(rem / den) on the cap width. Depends on rti_pkg.
module rti_div #(
   parameter int FRAC_BITS = 16,
   parameter int TAG_W = 2,
   localparam int WDOT = rti_pkg::SCALED_W - FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rti_pkg::SCALED_W-1:0]  in_rem,
   input  logic [WDOT-1:0]               in_den,
   input  logic [TAG_W-1:0]              in_tag,
   output logic                          out_valid,
   output logic [rti_pkg::TQ_W-1:0]      out_quot,
   output logic [TAG_W-1:0]              out_tag
);

   localparam int WS = rti_pkg::SCALED_W;
   localparam int NQ = rti_pkg::TQ_W;

   logic            vld_ff  [NQ];
   logic [WS-1:0]   rem_ff  [NQ];
   logic [WDOT-1:0] den_ff  [NQ];
   logic [NQ-1:0]   quot_ff [NQ];
   logic [TAG_W-1:0] tag_ff [NQ];

   genvar i;
   generate
      for (i = 0; i < NQ; i++) begin : g_stg
         localparam int B = NQ - 1 - i;
         logic             v_src;
         logic [WS-1:0]    r_src;
         logic [WDOT-1:0]  d_src;
         logic [NQ-1:0]    q_src;
         logic [TAG_W-1:0] t_src;
         logic             fit;
         logic [WS-1:0]    rem_in;
         logic [NQ-1:0]    quot_in;

         if (i == 0) begin : g_head
            assign v_src = in_valid;
            assign r_src = in_rem;
            assign d_src = in_den;
            assign q_src = '0;
            assign t_src = in_tag;
         end else begin : g_body
            assign v_src = vld_ff[i-1];
            assign r_src = rem_ff[i-1];
            assign d_src = den_ff[i-1];
            assign q_src = quot_ff[i-1];
            assign t_src = tag_ff[i-1];
         end

         always_comb begin
            fit     = (r_src >> B) >= WS'(d_src);
            rem_in  = fit ? r_src - (WS'(d_src) << B) : r_src;
            quot_in = q_src;
            quot_in[B] = fit;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (en) begin
               vld_ff[i] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i]  <= rem_in;
               den_ff[i]  <= d_src;
               quot_ff[i] <= quot_in;
               tag_ff[i]  <= t_src;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[NQ-1];
   assign out_quot  = quot_ff[NQ-1];
   assign out_tag   = tag_ff[NQ-1];

endmodule

// ----- src/rti_point.sv -----
// Hit point stages: direction times t in split products, saturated point,
// far flag and sum of squared offsets. Five register stages. Depends on rti_pkg.
module rti_point #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rti_pkg::TQ_W-1:0]      in_tq,
   input  logic                          in_miss,
   input  rti_pkg::coord_type            org [rti_pkg::NUM_AX],
   input  rti_pkg::coord_type            dir [rti_pkg::NUM_AX],
   output logic                          out_valid,
   output rti_pkg::sq_tag_type           out_tag,
   output logic [rti_pkg::SUMSQ_W-1:0]   out_sumsq
);

   localparam int NA   = rti_pkg::NUM_AX;
   localparam int CW   = rti_pkg::COORD_W;
   localparam int H    = rti_pkg::TQ_HALF;
   localparam int TW   = rti_pkg::TQ_W;
   localparam int WM   = CW + H + 1;
   localparam int WPR  = CW + TW + 1;
   localparam int WOFF = WPR - FRAC_BITS;
   localparam int WPT  = WOFF + 1;
   localparam int MW   = CW - 1;
   localparam int SQW  = 2 * MW;
   localparam int SW   = rti_pkg::SUMSQ_W;
   localparam int NSTG = 5;
   localparam logic signed [WOFF-1:0] OFF_LIM = WOFF'(rti_pkg::COORD_MAX);
   localparam logic signed [WPT-1:0]  PT_HI   = WPT'(rti_pkg::COORD_MAX);
   localparam logic signed [WPT-1:0]  PT_LO   = WPT'(rti_pkg::COORD_MIN);

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-2:0] miss_ff;

   logic signed [WM-1:0]   plo_in [NA], phi_in [NA], plo_ff [NA], phi_ff [NA];
   logic signed [WOFF-1:0] off_in [NA], off_ff [NA];
   logic signed [WPT-1:0]  sum_pt [NA];
   logic signed [WOFF-1:0] off_abs [NA];
   rti_pkg::coord_type     pt_in [NA], pt_s3_ff [NA], pt_s4_ff [NA];
   logic [NA-1:0]          far_ax;
   logic [MW-1:0]          mag_in [NA], mag_ff [NA];
   logic                   far_s3_ff, far_s4_ff;
   logic [SQW-1:0]         sq_in [NA], sq_ff [NA];
   logic [SW-1:0]          sumsq_in;
   rti_pkg::sq_tag_type    tag_in, tag_ff;
   logic [SW-1:0]          sumsq_ff;

   genvar k;
   generate
      for (k = 0; k < NA; k++) begin : g_ax
         assign plo_in[k] = WM'(dir[k] * $signed({1'b0, in_tq[H-1:0]}));
         assign phi_in[k] = WM'(dir[k] * $signed({1'b0, in_tq[TW-1:H]}));
         assign off_in[k] = WOFF'(((WPR'(phi_ff[k]) <<< H) + WPR'(plo_ff[k])) >>> FRAC_BITS);
         assign sum_pt[k] = WPT'(org[k]) + WPT'(off_ff[k]);
         assign pt_in[k]  = (sum_pt[k] > PT_HI) ? rti_pkg::COORD_MAX :
                            (sum_pt[k] < PT_LO) ? rti_pkg::COORD_MIN :
                            rti_pkg::coord_type'(sum_pt[k][CW-1:0]);
         assign far_ax[k] = (off_ff[k] > OFF_LIM) || (off_ff[k] < -OFF_LIM);
         assign off_abs[k] = off_ff[k][WOFF-1] ? -off_ff[k] : off_ff[k];
         assign mag_in[k] = off_abs[k][MW-1:0];
         assign sq_in[k]  = SQW'(mag_ff[k] * mag_ff[k]);
      end
   endgenerate

   always_comb begin
      sumsq_in    = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      tag_in.miss = miss_ff[NSTG-2];
      tag_in.far  = far_s4_ff;
      tag_in.px   = pt_s4_ff[0];
      tag_in.py   = pt_s4_ff[1];
      tag_in.pz   = pt_s4_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss_ff   <= {miss_ff[NSTG-3:0], in_miss};
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         off_ff    <= off_in;
         pt_s3_ff  <= pt_in;
         far_s3_ff <= |far_ax;
         mag_ff    <= mag_in;
         pt_s4_ff  <= pt_s3_ff;
         far_s4_ff <= far_s3_ff;
         sq_ff     <= sq_in;
         tag_ff    <= tag_in;
         sumsq_ff  <= sumsq_in;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_tag   = tag_ff;
   assign out_sumsq = sumsq_ff;

endmodule

// ----- src/rti_isqrt.sv -----
// Pipelined integer square root, two radicand bits per register stage.
// Carries a tag alongside each value. Depends on rti_pkg.
module rti_isqrt #(
   parameter int TAG_W = 98
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rti_pkg::SUMSQ_W-1:0]   in_x,
   input  logic [TAG_W-1:0]              in_tag,
   output logic                          out_valid,
   output logic [rti_pkg::ROOT_W-1:0]    out_root,
   output logic [TAG_W-1:0]              out_tag
);

   localparam int SW = rti_pkg::SUMSQ_W;
   localparam int NS = rti_pkg::ISQ_STEPS;

   logic             vld_ff [NS];
   logic [SW-1:0]    x_ff   [NS];
   logic [SW-1:0]    res_ff [NS];
   logic [TAG_W-1:0] tag_ff [NS];

   genvar i;
   generate
      for (i = 0; i < NS; i++) begin : g_stg
         localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * i);
         logic             v_src;
         logic [SW-1:0]    x_src;
         logic [SW-1:0]    r_src;
         logic [TAG_W-1:0] t_src;
         logic [SW-1:0]    trial;
         logic             fit;
         logic [SW-1:0]    x_in;
         logic [SW-1:0]    res_in;

         if (i == 0) begin : g_head
            assign v_src = in_valid;
            assign x_src = in_x;
            assign r_src = '0;
            assign t_src = in_tag;
         end else begin : g_body
            assign v_src = vld_ff[i-1];
            assign x_src = x_ff[i-1];
            assign r_src = res_ff[i-1];
            assign t_src = tag_ff[i-1];
         end

         always_comb begin
            trial  = r_src + BIT;
            fit    = x_src >= trial;
            x_in   = fit ? x_src - trial : x_src;
            res_in = fit ? (r_src >> 1) + BIT : r_src >> 1;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (en) begin
               vld_ff[i] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i]   <= x_in;
               res_ff[i] <= res_in;
               tag_ff[i] <= t_src;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[NS-1];
   assign out_root  = res_ff[NS-1][rti_pkg::ROOT_W-1:0];
   assign out_tag   = tag_ff[NS-1];

endmodule

// ----- src/ray_triangle_intersect.sv -----
// Ray/triangle intersection (Moller-Trumbore) in signed fixed point.
// Channels: req_ch takes one triangle (three vertices) per transaction;
// rsp_ch returns hit flag, hit point and distance for each, in order;
// csr_ch writes the ray origin and direction registers (index 0..5, others
// dropped) and is always ready. Write the registers only while no triangle
// is in flight.
// Pipeline, from request transaction to response valid:
// 8 stages of edge/cross/dot arithmetic, 62 divider stages (one quotient
// bit each), 5 hit point stages, 32 square root stages, 1 output register.
// Throughput: one triangle per cycle when not stalled; one enable advances all.
// Stall: an output register plus one skid entry sit after the pipe; the pipe
// holds only once the skid entry is full, so triangles are still taken
// while a response waits. req_ch.ready is a register output.
// Reset: zeroes the ray registers and valid flags; drops everything in flight.
// Depends on rti_pkg, rti_if, rti_geom, rti_div, rti_point, rti_isqrt.
module ray_triangle_intersect #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rti_req_if.sink    req_ch,
   rti_rsp_if.source  rsp_ch,
   rti_csr_if.sink    csr_ch
);

   localparam int NA   = rti_pkg::NUM_AX;
   localparam int WDOT = rti_pkg::SCALED_W - FRAC_BITS;
   localparam int RW   = rti_pkg::ROOT_W;
   localparam int DTW  = $bits(rti_pkg::div_tag_type);
   localparam int STW  = $bits(rti_pkg::sq_tag_type);

   rti_pkg::coord_type org_ff [NA], dir_ff [NA];
   rti_pkg::coord_type vert0 [NA], vert1 [NA], vert2 [NA];

   logic                         en;
   logic                         geo_valid;
   logic [rti_pkg::SCALED_W-1:0] geo_rem;
   logic [WDOT-1:0]              geo_den;
   rti_pkg::div_tag_type         geo_tag;
   logic                         div_valid;
   logic [rti_pkg::TQ_W-1:0]     div_quot;
   rti_pkg::div_tag_type         div_tag;
   logic [rti_pkg::TQ_W-1:0]     tq;
   logic                         pt_valid;
   rti_pkg::sq_tag_type          pt_tag;
   logic [rti_pkg::SUMSQ_W-1:0]  pt_sumsq;
   logic                         sq_valid;
   logic [RW-1:0]                sq_root;
   rti_pkg::sq_tag_type          sq_tag;
   rti_pkg::rsp_type             item;
   logic                         new_item;
   logic                         out_take;

   logic             out_vld_ff, skid_vld_ff;
   rti_pkg::rsp_type out_ff, skid_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '{default: '0};
         dir_ff <= '{default: '0};
      end else if (csr_ch.valid) begin
         case (rti_pkg::csr_idx_type'(csr_ch.index))
            rti_pkg::REG_ORIGIN_X:    org_ff[0] <= csr_ch.data;
            rti_pkg::REG_ORIGIN_Y:    org_ff[1] <= csr_ch.data;
            rti_pkg::REG_ORIGIN_Z:    org_ff[2] <= csr_ch.data;
            rti_pkg::REG_DIRECTION_X: dir_ff[0] <= csr_ch.data;
            rti_pkg::REG_DIRECTION_Y: dir_ff[1] <= csr_ch.data;
            rti_pkg::REG_DIRECTION_Z: dir_ff[2] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   assign vert0 = '{req_ch.vert0_x, req_ch.vert0_y, req_ch.vert0_z};
   assign vert1 = '{req_ch.vert1_x, req_ch.vert1_y, req_ch.vert1_z};
   assign vert2 = '{req_ch.vert2_x, req_ch.vert2_y, req_ch.vert2_z};

   // advance the whole pipe while the skid entry is free
   assign en           = !skid_vld_ff;
   assign req_ch.ready = en;

   rti_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .vert0     (vert0),
      .vert1     (vert1),
      .vert2     (vert2),
      .org       (org_ff),
      .dir       (dir_ff),
      .out_valid (geo_valid),
      .out_rem   (geo_rem),
      .out_den   (geo_den),
      .out_tag   (geo_tag)
   );

   rti_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(DTW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geo_valid),
      .in_rem    (geo_rem),
      .in_den    (geo_den),
      .in_tag    (geo_tag),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   // cap t when the quotient does not fit
   assign tq = div_tag.ovf ? '1 : div_quot;

   rti_point #(.FRAC_BITS(FRAC_BITS)) u_point (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_tq     (tq),
      .in_miss   (div_tag.miss),
      .org       (org_ff),
      .dir       (dir_ff),
      .out_valid (pt_valid),
      .out_tag   (pt_tag),
      .out_sumsq (pt_sumsq)
   );

   rti_isqrt #(.TAG_W(STW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pt_valid),
      .in_x      (pt_sumsq),
      .in_tag    (pt_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   always_comb begin
      item = '0;
      if (!sq_tag.miss) begin
         item.hit     = 1'b1;
         item.point_x = sq_tag.px;
         item.point_y = sq_tag.py;
         item.point_z = sq_tag.pz;
         item.distance = (sq_tag.far || (sq_root > RW'(rti_pkg::DIST_MAX)))
                       ? rti_pkg::DIST_MAX : sq_root[rti_pkg::DIST_W-1:0];
      end
   end

   assign new_item = en && sq_valid;
   assign out_take = out_vld_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || out_take) begin
         out_vld_ff  <= skid_vld_ff || new_item;
         skid_vld_ff <= 1'b0;
      end else if (new_item) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || out_take) begin
         out_ff <= skid_vld_ff ? skid_ff : item;
      end else if (new_item) begin
         skid_ff <= item;
      end
   end

   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.hit      = out_ff.hit;
   assign rsp_ch.point_x  = out_ff.point_x;
   assign rsp_ch.point_y  = out_ff.point_y;
   assign rsp_ch.point_z  = out_ff.point_z;
   assign rsp_ch.distance = out_ff.distance;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held without an output entry");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.hit) |-> (rsp_ch.point_x == 0 && rsp_ch.point_y == 0
                                         && rsp_ch.point_z == 0 && rsp_ch.distance == 0))
      else $error("miss response carries nonzero fields");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_ch.ready))
      else $error("skid entry filled while output was free");

endmodule
